>>> sv/cc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc_pkg: shared types and constants of the comment classifier
// Character codes, comment kinds, scanner states and the result word layout.
// ----------------------------------------------------------------------------
package cc_pkg;

    // Characters the scanner looks for
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Comment kinds
    localparam logic [2:0] KIND_C_PLAIN   = 3'd0;
    localparam logic [2:0] KIND_JD        = 3'd1;
    localparam logic [2:0] KIND_JD_AFTER  = 3'd2;
    localparam logic [2:0] KIND_QT        = 3'd3;
    localparam logic [2:0] KIND_QT_AFTER  = 3'd4;
    localparam logic [2:0] KIND_CPP_PLAIN = 3'd5;
    localparam logic [2:0] KIND_CPP_BLOCK = 3'd6;

    // Request types
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_EOF  = 1'b1;

    // Words per input item and queue geometry
    localparam int NRES   = 5;
    localparam int CNT_W  = $clog2(NRES + 1);
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Scanner states
    typedef enum logic [9:0] {
        M_CODE       = 10'b00_0000_0001,
        M_DQ         = 10'b00_0000_0010,
        M_DQ_ESC     = 10'b00_0000_0100,
        M_SQ         = 10'b00_0000_1000,
        M_SQ_ESC     = 10'b00_0001_0000,
        M_SLASH      = 10'b00_0010_0000,
        M_LOOK       = 10'b00_0100_0000,
        M_BLOCK      = 10'b00_1000_0000,
        M_BLOCK_STAR = 10'b01_0000_0000,
        M_LINE       = 10'b10_0000_0000
    } mode_t;

    // One output word
    typedef struct packed {
        logic [7:0] data;
        logic       comment;
        logic       cbegin;
        logic       cend;
        logic [2:0] kind;
    } res_t;

    // All words caused by one input item
    typedef struct packed {
        logic [CNT_W-1:0]     cnt;
        res_t [NRES-1:0]      r;
    } bundle_t;

    // Queue status toward the scanner and the serializer
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic res_t make_res(input logic [7:0] d, input logic com,
                                      input logic beg, input logic fin,
                                      input logic [2:0] k);
        res_t r;
        r.data    = d;
        r.comment = com;
        r.cbegin  = beg;
        r.cend    = fin;
        r.kind    = k;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/cc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc_in_if: source byte channel
// Valid/ready channel carrying one source byte or an end-of-file request.
// ----------------------------------------------------------------------------
interface cc_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_byte;

    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface
`default_nettype wire

>>> sv/cc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc_out_if: tagged byte channel
// Valid/ready channel carrying one classified byte and its comment tags.
// ----------------------------------------------------------------------------
interface cc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_comment;
    logic       comment_begin;
    logic       comment_end;
    logic [2:0] comment_kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output is_comment,
                    output comment_begin, output comment_end,
                    output comment_kind, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input is_comment,
                    input comment_begin, input comment_end,
                    input comment_kind, input last_of_run, output ready);
endinterface
`default_nettype wire

>>> sv/cc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc_front: scanner front end
// Takes one byte per cycle unless the queue is full, tracks strings and
// comments, holds comment lookahead and builds each byte's tagged word group.
// ----------------------------------------------------------------------------
module cc_front import cc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cc_in_if.sink      in_ch,
    input  wire logic  q_full,
    output logic       push,
    output bundle_t    push_data
);

    mode_t            mode_reg, mode_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [2:0]       kind_reg, kind_next;
    logic [7:0]       lb_reg [4];
    logic [7:0]       lb_next [4];

    logic [7:0]       c;
    logic [7:0]       nb [4];
    logic [2:0]       n;
    logic             blk;
    logic             cls_done;
    logic             cls_closed;
    logic [2:0]       cls_kind;
    logic             accept;
    bundle_t          bund;

    assign c           = in_ch.in_byte;
    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign push        = accept && (bund.cnt != '0);
    assign push_data   = bund;

    // Lookahead as it stands with the incoming byte added
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            nb[i] = (cnt_reg[1:0] == 2'(i)) ? c : lb_reg[i];
        end
        n = cnt_reg + 3'd1;
    end

    // Classify the comment from the held opener and lookahead bytes
    always_comb
    begin
        blk        = (nb[0] == CH_STAR);
        cls_done   = 1'b1;
        cls_closed = 1'b0;
        if (blk)
        begin
            cls_kind = KIND_C_PLAIN;
            if (n == 3'd2)
            begin
                cls_done = !((nb[1] == CH_STAR) || (nb[1] == CH_BANG));
            end
            else if (n == 3'd3)
            begin
                if (is_ws(nb[2]))
                begin
                    cls_kind = (nb[1] == CH_STAR) ? KIND_JD : KIND_QT;
                end
                else if (nb[2] == CH_LT)
                begin
                    cls_done = 1'b0;
                end
                else
                begin
                    cls_closed = (nb[1] == CH_STAR) && (nb[2] == CH_SLASH);
                end
            end
            else if (is_ws(nb[3]))
            begin
                cls_kind = (nb[1] == CH_STAR) ? KIND_JD_AFTER : KIND_QT_AFTER;
            end
        end
        else
        begin
            cls_kind = KIND_CPP_PLAIN;
            if (n == 3'd2)
            begin
                cls_done = !((nb[1] == CH_SLASH) || (nb[1] == CH_BANG));
            end
            else if (n == 3'd3)
            begin
                if (nb[1] == CH_SLASH)
                begin
                    if (is_ws(nb[2]))
                    begin
                        cls_kind = KIND_CPP_BLOCK;
                    end
                end
                else if (is_ws(nb[2]))
                begin
                    cls_kind = KIND_QT;
                end
                else
                begin
                    cls_done = (nb[2] != CH_LT);
                end
            end
            else if (is_ws(nb[3]))
            begin
                cls_kind = KIND_QT_AFTER;
            end
        end
    end

    // Next state and the words released by this byte
    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        kind_next = kind_reg;
        for (int i = 0; i < 4; i++)
        begin
            lb_next[i] = lb_reg[i];
        end
        bund = '0;

        if (in_ch.req_type == REQ_EOF)
        begin
            // Flush held lookahead without an end mark, then reset
            if (mode_reg == M_LOOK)
            begin
                bund.r[0] = make_res(CH_SLASH, 1'b1, 1'b1, 1'b0, kind_reg);
                for (int i = 1; i < 4; i++)
                begin
                    if (3'(i) <= cnt_reg)
                    begin
                        bund.r[i] = make_res(lb_reg[i-1], 1'b1, 1'b0, 1'b0, kind_reg);
                    end
                end
                bund.cnt = cnt_reg + 3'd1;
            end
            mode_next = M_CODE;
            cnt_next  = '0;
            kind_next = KIND_C_PLAIN;
        end
        else
        begin
            case (mode_reg)
                M_DQ, M_SQ:
                begin
                    bund.cnt  = 3'd1;
                    bund.r[0] = make_res(c, 1'b0, 1'b0, 1'b0, KIND_C_PLAIN);
                    if (c == CH_BSLASH)
                    begin
                        mode_next = (mode_reg == M_DQ) ? M_DQ_ESC : M_SQ_ESC;
                    end
                    else if (c == ((mode_reg == M_DQ) ? CH_DQUOTE : CH_SQUOTE))
                    begin
                        mode_next = M_CODE;
                    end
                end
                M_DQ_ESC:
                begin
                    bund.cnt  = 3'd1;
                    bund.r[0] = make_res(c, 1'b0, 1'b0, 1'b0, KIND_C_PLAIN);
                    mode_next = M_DQ;
                end
                M_SQ_ESC:
                begin
                    bund.cnt  = 3'd1;
                    bund.r[0] = make_res(c, 1'b0, 1'b0, 1'b0, KIND_C_PLAIN);
                    mode_next = M_SQ;
                end
                M_SLASH:
                begin
                    if ((c == CH_STAR) || (c == CH_SLASH))
                    begin
                        lb_next[0] = c;
                        cnt_next   = 3'd1;
                        kind_next  = (c == CH_STAR) ? KIND_C_PLAIN : KIND_CPP_PLAIN;
                        mode_next  = M_LOOK;
                    end
                    else
                    begin
                        // Lone slash is code; the byte after it is plain code
                        bund.cnt  = 3'd2;
                        bund.r[0] = make_res(CH_SLASH, 1'b0, 1'b0, 1'b0, KIND_C_PLAIN);
                        bund.r[1] = make_res(c, 1'b0, 1'b0, 1'b0, KIND_C_PLAIN);
                        if (c == CH_DQUOTE)
                        begin
                            mode_next = M_DQ;
                        end
                        else if (c == CH_SQUOTE)
                        begin
                            mode_next = M_SQ;
                        end
                        else
                        begin
                            mode_next = M_CODE;
                        end
                    end
                end
                M_LOOK:
                begin
                    if (!cls_done)
                    begin
                        lb_next[cnt_reg[1:0]] = c;
                        cnt_next              = n;
                    end
                    else
                    begin
                        // Release opener and held bytes as one run
                        kind_next = cls_kind;
                        cnt_next  = '0;
                        bund.r[0] = make_res(CH_SLASH, 1'b1, 1'b1, 1'b0, cls_kind);
                        for (int i = 1; i < 4; i++)
                        begin
                            if (3'(i) <= cnt_reg)
                            begin
                                bund.r[i] = make_res(lb_reg[i-1], 1'b1, 1'b0, 1'b0,
                                                     cls_kind);
                            end
                        end
                        if (blk && (c == CH_STAR))
                        begin
                            // Hold the trailing star as pending
                            bund.cnt  = n;
                            mode_next = M_BLOCK_STAR;
                        end
                        else
                        begin
                            bund.cnt = cnt_reg + 3'd2;
                            if (blk && cls_closed)
                            begin
                                bund.r[n] = make_res(c, 1'b1, 1'b0, 1'b1, cls_kind);
                                mode_next = M_CODE;
                            end
                            else if (!blk && (c == CH_NL))
                            begin
                                bund.r[n] = make_res(c, 1'b0, 1'b0, 1'b1, cls_kind);
                                mode_next = M_CODE;
                            end
                            else
                            begin
                                bund.r[n] = make_res(c, 1'b1, 1'b0, 1'b0, cls_kind);
                                mode_next = blk ? M_BLOCK : M_LINE;
                            end
                        end
                    end
                end
                M_BLOCK:
                begin
                    if (c == CH_STAR)
                    begin
                        mode_next = M_BLOCK_STAR;
                    end
                    else
                    begin
                        bund.cnt  = 3'd1;
                        bund.r[0] = make_res(c, 1'b1, 1'b0, 1'b0, kind_reg);
                    end
                end
                M_BLOCK_STAR:
                begin
                    bund.r[0] = make_res(CH_STAR, 1'b1, 1'b0, 1'b0, kind_reg);
                    if (c == CH_SLASH)
                    begin
                        bund.cnt  = 3'd2;
                        bund.r[1] = make_res(c, 1'b1, 1'b0, 1'b1, kind_reg);
                        mode_next = M_CODE;
                    end
                    else if (c != CH_STAR)
                    begin
                        bund.cnt  = 3'd2;
                        bund.r[1] = make_res(c, 1'b1, 1'b0, 1'b0, kind_reg);
                        mode_next = M_BLOCK;
                    end
                    else
                    begin
                        bund.cnt = 3'd1;
                    end
                end
                M_LINE:
                begin
                    bund.cnt = 3'd1;
                    if (c == CH_NL)
                    begin
                        bund.r[0] = make_res(c, 1'b0, 1'b0, 1'b1, kind_reg);
                        mode_next = M_CODE;
                    end
                    else
                    begin
                        bund.r[0] = make_res(c, 1'b1, 1'b0, 1'b0, kind_reg);
                    end
                end
                default:
                begin
                    // Plain code
                    mode_next = M_CODE;
                    if (c == CH_SLASH)
                    begin
                        mode_next = M_SLASH;
                    end
                    else
                    begin
                        bund.cnt  = 3'd1;
                        bund.r[0] = make_res(c, 1'b0, 1'b0, 1'b0, KIND_C_PLAIN);
                        if (c == CH_DQUOTE)
                        begin
                            mode_next = M_DQ;
                        end
                        else if (c == CH_SQUOTE)
                        begin
                            mode_next = M_SQ;
                        end
                    end
                end
            endcase
        end
    end

    // Advance scanner state on each accepted input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_CODE;
            cnt_reg  <= '0;
            kind_reg <= KIND_C_PLAIN;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            kind_reg <= kind_next;
        end
    end

    // Hold lookahead bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 4; i++)
            begin
                lb_reg[i] <= lb_next[i];
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/cc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc_fifo: word group queue
// Short queue of word groups between the scanner and the serializer.
// ----------------------------------------------------------------------------
module cc_fifo import cc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire bundle_t push_data,
    input  wire logic    pop,
    output bundle_t      pop_data,
    output fifo_stat_t   stat
);

    bundle_t           mem_reg [QDEPTH];
    logic [QAW-1:0]    wr_reg;
    logic [QAW-1:0]    rd_reg;
    logic [QAW:0]      count_reg;
    logic [QAW:0]      count_next;

    assign stat.full  = (count_reg == (QAW+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = mem_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store groups
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

>>> sv/cc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc_back: word serializer
// Pops one word group at a time and sends its words out one per cycle while
// out_ch is ready, marking the last word of each group.
// ----------------------------------------------------------------------------
module cc_back import cc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire fifo_stat_t stat,
    input  wire bundle_t    pop_data,
    output logic            pop,
    cc_out_if.source        out_ch
);

    bundle_t           cur_reg;
    logic              have_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              fire;
    logic              last;
    res_t              res;

    assign res  = cur_reg.r[idx_reg];
    assign last = (idx_reg == (cur_reg.cnt - 1'b1));
    assign fire = out_ch.valid && out_ch.ready;
    assign pop  = !stat.empty && (!have_reg || (fire && last));

    assign out_ch.valid         = have_reg;
    assign out_ch.out_byte      = res.data;
    assign out_ch.is_comment    = res.comment;
    assign out_ch.comment_begin = res.cbegin;
    assign out_ch.comment_end   = res.cend;
    assign out_ch.comment_kind  = res.kind;
    assign out_ch.last_of_run   = last;

    // Track which group is in flight and which word of it goes out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            have_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                have_reg <= 1'b0;
                idx_reg  <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Load the next group
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_data;
        end
    end

endmodule
`default_nettype wire

>>> sv/c_comment_classifier.sv
// Path: a byte's group is written into the queue, then loaded into the serializer's group register.
// Throughput: one source byte per cycle in, one tagged word per cycle out while the
// receiver is ready; a byte's words leave one after another, and the 4-group queue
// between scanner and serializer sets how far input runs ahead before it stalls.
// Reset: rst_n clears scanner state, queue and serializer at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_comment_classifier: streaming C/C++ comment classifier
// Tags every source byte as code or comment and classifies each comment.
// ----------------------------------------------------------------------------
module c_comment_classifier import cc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cc_in_if.sink      in_ch,
    cc_out_if.source   out_ch
);

    logic        push;
    bundle_t     push_data;
    logic        pop;
    bundle_t     pop_data;
    fifo_stat_t  stat;

    // Scan and classify
    cc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .q_full    (stat.full),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple scanner from output
    cc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (stat)
    );

    // Serialize words
    cc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .pop_data (pop_data),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule
`default_nettype wire
